// ----- design/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define CHK_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- design/hpq_pkg.sv -----
`default_nettype none

package hpq_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int ENTRY_W  = 6;

    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    localparam logic [1:0] STATUS_DONE  = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic                     action;
        logic signed [DATA_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] removed_value;
        logic [1:0]               status;
        logic [ENTRY_W-1:0]       entry_count;
    } result_t;

    // Contents of one slot of the sorted chain.
    typedef struct packed {
        logic                     valid;
        logic signed [DATA_W-1:0] value;
    } slot_t;

    // What a cell shows to its right-hand neighbor.
    typedef struct packed {
        slot_t slot;
        logic  keep;
    } cell_link_t;

    // Operation broadcast to every cell.
    typedef struct packed {
        logic                     ins;
        logic                     rem;
        logic signed [DATA_W-1:0] value;
    } cell_cmd_t;

endpackage

`default_nettype wire

// ----- design/hpq_cell.sv -----
`default_nettype none

module hpq_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hpq_pkg::cell_cmd_t cmd,
    input  wire hpq_pkg::cell_link_t left,
    input  wire hpq_pkg::slot_t     right,
    output hpq_pkg::cell_link_t     link
);

    hpq_pkg::slot_t slot_reg;
    hpq_pkg::slot_t slot_next;
    logic           keep;

    // A valid entry at least as large as the new value stays where it is.
    assign keep = slot_reg.valid && (slot_reg.value >= cmd.value);

    always_comb
    begin
        slot_next = slot_reg;
        if (cmd.rem)
        begin
            slot_next = right;
        end
        else if (cmd.ins && !keep)
        begin
            if (left.keep)
            begin
                slot_next.valid = 1'b1;
                slot_next.value = cmd.value;
            end
            else
            begin
                slot_next = left.slot;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else
        begin
            slot_reg <= slot_next;
        end
    end

    assign link.slot = slot_reg;
    assign link.keep = keep;

endmodule

`default_nettype wire

// ----- design/max_heap_priority_queue_top.sv -----
`default_nettype none

// Bounded max-priority queue of signed 32-bit values.
// A request item is taken at a rising clock edge where start is high and busy is
// low. Its action field selects an insert of value or a removal of the largest
// value held. Busy is always low, so a new item may be given in every cycle.
// Exactly one result item follows each request, in the cycle after it is taken,
// with done high for that single cycle. The result carries the removed value (zero
// unless a removal succeeded), a status code and the number of entries now held.
// An insert into a full queue is dropped with status full, and a removal from an
// empty queue reports status empty; neither changes the contents.
// Values are kept sorted, largest first, in a row of identical cells. On an insert
// every cell compares its entry with the new value in parallel and either keeps
// its entry, takes the new value, or takes its left neighbor's entry. On a removal
// every cell takes its right neighbor's entry. Each item therefore needs only
// a single compare in each cell, for a sustained rate of one item per cycle.
// The receiver cannot stall: a result is lost if it is not taken while done is high.
// Reset clears the entry count and every valid bit in the row, leaving the queue empty.
module max_heap_priority_queue_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire hpq_pkg::request_t request,
    output logic                   done,
    output hpq_pkg::result_t       result
);

    logic                          accept;
    logic                          is_full;
    logic                          is_empty;
    hpq_pkg::cell_cmd_t            cmd;
    hpq_pkg::cell_link_t           links [hpq_pkg::CAPACITY];

    logic [hpq_pkg::COUNT_W-1:0]   count_reg;
    logic [hpq_pkg::COUNT_W-1:0]   count_next;
    logic                          done_reg;
    hpq_pkg::result_t              result_reg;
    hpq_pkg::result_t              result_next;

    // Every item finishes in the cycle it is taken, so the block never holds off.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign is_full  = (count_reg == hpq_pkg::COUNT_W'(hpq_pkg::CAPACITY));
    assign is_empty = (count_reg == '0);

    assign cmd.ins   = accept && (request.action == hpq_pkg::ACT_INSERT) && !is_full;
    assign cmd.rem   = accept && (request.action == hpq_pkg::ACT_REMOVE) && !is_empty;
    assign cmd.value = request.value;

    // The row of cells; the leftmost cell holds the largest value.
    for (genvar i = 0; i < hpq_pkg::CAPACITY; i++)
    begin : g_cell
        hpq_pkg::cell_link_t left_in;
        hpq_pkg::slot_t      right_in;

        if (i == 0)
        begin : g_head
            // Nothing stands left of the head, so a new value may always land here.
            assign left_in.slot.valid = 1'b0;
            assign left_in.slot.value = '0;
            assign left_in.keep       = 1'b1;
        end
        else
        begin : g_body
            assign left_in = links[i-1];
        end

        if (i == hpq_pkg::CAPACITY - 1)
        begin : g_tail
            assign right_in.valid = 1'b0;
            assign right_in.value = '0;
        end
        else
        begin : g_inner
            assign right_in = links[i+1].slot;
        end

        hpq_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (cmd),
            .left  (left_in),
            .right (right_in),
            .link  (links[i])
        );
    end

    always_comb
    begin
        count_next                = count_reg;
        result_next.removed_value = '0;
        result_next.status        = hpq_pkg::STATUS_DONE;
        if (accept)
        begin
            if (request.action == hpq_pkg::ACT_INSERT)
            begin
                if (is_full)
                begin
                    result_next.status = hpq_pkg::STATUS_FULL;
                end
                else
                begin
                    count_next = count_reg + hpq_pkg::COUNT_W'(1);
                end
            end
            else
            begin
                if (is_empty)
                begin
                    result_next.status = hpq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    count_next                = count_reg - hpq_pkg::COUNT_W'(1);
                    result_next.removed_value = links[0].slot.value;
                end
            end
        end
        result_next.entry_count = hpq_pkg::ENTRY_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ----- design/hpq_checker.sv -----
`default_nettype none

`include "assert_macros.svh"

module hpq_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire hpq_pkg::request_t request,
    input wire logic              done,
    input wire hpq_pkg::result_t  result
);

    // Each taken request yields its result in the following cycle.
    `CHK_ASSERT(a_result_follows, (start && !busy) |=> done, "request produced no result")

    // No result appears without a request taken in the previous cycle.
    `CHK_ASSERT(a_no_spurious, done |-> $past(start && !busy), "result without request")

    // An empty removal reports an empty queue and no value.
    `CHK_ASSERT(a_empty_report,
        (done && (result.status == hpq_pkg::STATUS_EMPTY)) |->
        ((result.entry_count == '0) && (result.removed_value == '0)),
        "empty removal reported wrong count or value")

    // A dropped insert leaves the queue at capacity.
    `CHK_ASSERT(a_full_report,
        (done && (result.status == hpq_pkg::STATUS_FULL)) |->
        (result.entry_count == hpq_pkg::ENTRY_W'(hpq_pkg::CAPACITY)),
        "full insert reported wrong count")

    // Only the three defined status codes are ever reported.
    `CHK_ASSERT(a_status_code,
        done |-> ((result.status == hpq_pkg::STATUS_DONE) ||
                  (result.status == hpq_pkg::STATUS_EMPTY) ||
                  (result.status == hpq_pkg::STATUS_FULL)),
        "undefined status code")

endmodule

bind max_heap_priority_queue_top hpq_checker u_hpq_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);

`default_nettype wire

// ----- tb/sv/tb_max_heap_priority_queue_top.sv -----
`timescale 1ns / 100ps

module tb_max_heap_priority_queue_top;

    // The watchdog ends the run after this many cycles with no item taken and no
    // result seen. The longest legal quiet stretch is the longest sender gap and the
    // wait for the result that follows it, so this leaves a wide margin.
    localparam int QUIET_LIMIT = 500;

    // Cycles allowed after the last result before the final verdict. The block
    // answers in the cycle after it takes an item, so this covers any stray result.
    localparam int TAIL_CYCLES = 20;

    // Holds a software copy of the queue as an array-based binary max-heap, works
    // out the result of every item the block takes, and compares each result the
    // block gives against the oldest outcome still waiting.
    class hpq_scoreboard;

        logic signed [hpq_pkg::DATA_W-1:0] heap_slots[hpq_pkg::CAPACITY];
        int                                held;
        hpq_pkg::result_t                  heap_outcomes[$];
        int unsigned                       failures;
        int unsigned                       n_insert;
        int unsigned                       n_remove;
        int unsigned                       n_full;
        int unsigned                       n_empty;
        int                                peak;

        function new();
            held     = 0;
            failures = 0;
            n_insert = 0;
            n_remove = 0;
            n_full   = 0;
            n_empty  = 0;
            peak     = 0;
        endfunction

        function void swap_slots(int a, int b);
            logic signed [hpq_pkg::DATA_W-1:0] t;
            t             = heap_slots[a];
            heap_slots[a] = heap_slots[b];
            heap_slots[b] = t;
        endfunction

        // A new entry climbs while it is strictly larger than its parent, so an
        // equal value stays below the one already held.
        function void sift_up(int pos);
            int parent;
            while (pos > 0) begin
                parent = (pos - 1) / 2;
                if (!(heap_slots[pos] > heap_slots[parent]))
                    break;
                swap_slots(pos, parent);
                pos = parent;
            end
        endfunction

        // The moved entry sinks toward the larger child; the left child wins a tie
        // and an equal child never passes its parent.
        function void sift_down(int pos);
            int left;
            int right;
            int best;
            forever begin
                left  = 2 * pos + 1;
                right = left + 1;
                best  = pos;
                if (left < held && heap_slots[left] > heap_slots[best])
                    best = left;
                if (right < held && heap_slots[right] > heap_slots[best])
                    best = right;
                if (best == pos)
                    break;
                swap_slots(pos, best);
                pos = best;
            end
        endfunction

        function hpq_pkg::result_t heap_step(hpq_pkg::request_t req);
            hpq_pkg::result_t o;
            o.removed_value = '0;
            o.status        = hpq_pkg::STATUS_DONE;
            if (req.action == hpq_pkg::ACT_INSERT) begin
                if (held >= hpq_pkg::CAPACITY) begin
                    o.status = hpq_pkg::STATUS_FULL;
                    n_full++;
                end
                else begin
                    heap_slots[held] = req.value;
                    held++;
                    sift_up(held - 1);
                    n_insert++;
                end
            end
            else begin
                if (held == 0) begin
                    o.status = hpq_pkg::STATUS_EMPTY;
                    n_empty++;
                end
                else begin
                    o.removed_value = heap_slots[0];
                    held--;
                    heap_slots[0] = heap_slots[held];
                    sift_down(0);
                    n_remove++;
                end
            end
            if (held > peak)
                peak = held;
            o.entry_count = held[hpq_pkg::ENTRY_W-1:0];
            return o;
        endfunction

        function void note_request(hpq_pkg::request_t req);
            heap_outcomes.push_back(heap_step(req));
        endfunction

        function void check_result(hpq_pkg::result_t got);
            hpq_pkg::result_t want;
            if (heap_outcomes.size() == 0) begin
                $error("result with no item outstanding: removed_value %0d status %0d count %0d",
                       got.removed_value, got.status, got.entry_count);
                failures++;
                return;
            end
            want = heap_outcomes.pop_front();
            if (got.removed_value !== want.removed_value) begin
                $error("removed_value: expected %0d, got %0d",
                       want.removed_value, got.removed_value);
                failures++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                failures++;
            end
            if (got.entry_count !== want.entry_count) begin
                $error("entry_count: expected %0d, got %0d",
                       want.entry_count, got.entry_count);
                failures++;
            end
        endfunction

        function int waiting();
            return heap_outcomes.size();
        endfunction

    endclass

    logic              clk;
    logic              rst_n   = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    hpq_pkg::request_t request = '0;
    logic              done;
    hpq_pkg::result_t  result;

    hpq_scoreboard sb;
    int            quiet_cycles = 0;

    max_heap_priority_queue_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Monitor. Inputs are driven and outputs updated by nonblocking assignments at
    // the rising edge, so the values read here are the ones the edge itself saw.
    // A result and a new item can meet at one edge; the result belongs to an
    // earlier item whose outcome is already queued, so the order does not matter.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done)
                sb.check_result(result);
            if (start && !busy)
                sb.note_request(request);
        end
    end

    // Watchdog: any item taken or any result seen counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Offer one item after an idle gap of the given length and hold it until the
    // block takes it. With a zero gap start stays high from the previous item, so
    // it never gets two assignments within one time step.
    task automatic send_item(input logic act, input logic signed [hpq_pkg::DATA_W-1:0] val,
                             input int gap);
        hpq_pkg::request_t req;
        req.action = act;
        req.value  = val;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Stop offering items until every outstanding result has come back. Outstanding
    // outcomes are read only once the clock has risen, so the last item taken is
    // already noted when read, and the next start is driven in a later time step.
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.waiting() != 0);
    endtask

    // Random value: mostly full 32-bit words, so every bit takes both values, with
    // a good share of tiny values to force ties and of the two extremes.
    function automatic logic signed [hpq_pkg::DATA_W-1:0] pick_value();
        int unsigned kind;
        kind = $urandom_range(0, 7);
        if (kind < 2)
            return $urandom_range(0, 6) - 3;
        else if (kind == 2)
            return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        else
            return $urandom;
    endfunction

    initial
    begin
        int unsigned insert_pct;
        bit          burst;
        int          gap;
        logic        act;

        sb = new();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Removal from an empty queue, both extremes of the value
        // range, zero and minus one, a run of equal values, removals that carry a
        // nonzero value to be ignored, and draining back down to empty.
        send_item(hpq_pkg::ACT_REMOVE, 32'sd0, 0);
        send_item(hpq_pkg::ACT_INSERT, 32'sd0, 0);
        send_item(hpq_pkg::ACT_INSERT, 32'sh7FFF_FFFF, 1);
        send_item(hpq_pkg::ACT_INSERT, 32'sh8000_0000, 0);
        send_item(hpq_pkg::ACT_INSERT, -32'sd1, 2);
        send_item(hpq_pkg::ACT_INSERT, 32'sd1, 0);
        send_item(hpq_pkg::ACT_INSERT, 32'sd5, 0);
        send_item(hpq_pkg::ACT_INSERT, 32'sd5, 0);
        send_item(hpq_pkg::ACT_INSERT, 32'sd5, 3);
        send_item(hpq_pkg::ACT_REMOVE, 32'sh7FFF_FFFF, 0);
        send_item(hpq_pkg::ACT_REMOVE, -32'sd1, 0);
        send_item(hpq_pkg::ACT_REMOVE, 32'sh5A5A_A5A5, 1);
        send_item(hpq_pkg::ACT_REMOVE, 32'sd0, 0);
        send_item(hpq_pkg::ACT_REMOVE, 32'sd0, 0);
        send_item(hpq_pkg::ACT_REMOVE, 32'sd0, 0);
        send_item(hpq_pkg::ACT_REMOVE, 32'sd0, 4);
        send_item(hpq_pkg::ACT_REMOVE, 32'sd0, 0);
        send_item(hpq_pkg::ACT_REMOVE, 32'sd0, 0);
        send_item(hpq_pkg::ACT_INSERT, 32'sh8000_0000, 0);
        send_item(hpq_pkg::ACT_INSERT, 32'sh8000_0000, 0);
        send_item(hpq_pkg::ACT_REMOVE, 32'sd0, 0);
        send_item(hpq_pkg::ACT_REMOVE, 32'sd0, 0);
        wait_drained();

        // Random part, in runs of 100 items. A filling run is mostly inserts and
        // pushes the queue to capacity and then into dropped inserts; a draining
        // run empties it and then tries removals from empty; a mixed run wanders
        // in between. Some runs send back to back, the others draw a random idle gap
        // before each item so idle time lands at every fill level.
        insert_pct = 50;
        burst      = 1'b0;
        for (int i = 0; i < 1600; i++) begin
            if (i % 100 == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 85;
                    1: insert_pct = 15;
                    default: insert_pct = 50;
                endcase
                burst = ($urandom_range(0, 3) == 0);
            end
            // Once in a while the sender holds off until everything has come back.
            if (i % 400 == 399)
                wait_drained();
            act = ($urandom_range(0, 99) < insert_pct) ? hpq_pkg::ACT_INSERT
                                                       : hpq_pkg::ACT_REMOVE;
            gap = burst ? 0 : $urandom_range(0, 12);
            send_item(act, pick_value(), gap);
        end
        start <= 1'b0;

        // Wait for every outstanding result; the watchdog bounds this wait.
        while (sb.waiting() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.waiting() != 0) begin
            $error("%0d results never arrived", sb.waiting());
            sb.failures++;
        end

        $display("Ran %0d inserts and %0d removals, peak fill %0d of %0d.",
                 sb.n_insert, sb.n_remove, sb.peak, hpq_pkg::CAPACITY);
        $display("Saw %0d inserts dropped when full and %0d removals from empty.",
                 sb.n_full, sb.n_empty);
        if (sb.failures == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
